// ===== sv/wmf_pkg.sv =====
// Package: shared constants and types for the window minimizer finder.
`default_nettype none
package wmf_pkg;
    localparam int KMER_LEN_DEF   = 19;
    localparam int WINDOW_LEN_DEF = 19;
    localparam int POS_W  = 32;
    localparam int DIST_W = 5;

    typedef struct packed {
        logic [7:0] symbol;
        logic       seq_end;
    } wmf_in_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic              is_first;
        logic [DIST_W-1:0] distance;
        logic [POS_W-1:0]  gap;
    } wmf_out_t;
endpackage
`default_nettype wire

// ===== sv/wmf_stream_if.sv =====
// Interface: valid/ready channel carrying one payload.
`default_nettype none
interface wmf_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/wmf_front.sv =====
// Front: shifts characters into the window and classifies window-complete items.
`default_nettype none
module wmf_front #(
    parameter int KMER_LEN   = wmf_pkg::KMER_LEN_DEF,
    parameter int WINDOW_LEN = wmf_pkg::WINDOW_LEN_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire wmf_pkg::wmf_in_t in_item,
    output logic      job_valid,
    input  wire logic job_ready,
    output logic [8*(WINDOW_LEN+KMER_LEN-1)-1:0] job_window,
    output logic [wmf_pkg::POS_W-1:0]            job_base,
    output logic      job_full,
    output logic      job_end
);
    import wmf_pkg::*;
    localparam int SPAN = WINDOW_LEN + KMER_LEN - 1;
    localparam int FW   = $clog2(SPAN + 1);

    logic [7:0]       win_reg [SPAN];
    logic [FW-1:0]    fill_reg, fill_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic             job_valid_reg;
    logic [8*SPAN-1:0] jw_reg;
    logic [POS_W-1:0] jb_reg;
    logic             jf_reg, je_reg;
    logic             take;

    assign in_ready = !job_valid_reg || job_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        fill_next = fill_reg;
        idx_next  = idx_reg + 1'b1;
        if (fill_reg != FW'(SPAN))
        begin
            fill_next = fill_reg + 1'b1;
        end
        if (in_item.seq_end)
        begin
            fill_next = '0;
            idx_next  = '0;
        end
    end

    // Build the window as it looks after this character: oldest at byte 0.
    logic [7:0] nw [SPAN];
    always_comb
    begin
        for (int i = 0; i < SPAN; i++)
        begin
            if (fill_reg == FW'(SPAN))
                nw[i] = (i == SPAN-1) ? in_item.symbol : win_reg[i+1];
            else
                nw[i] = (FW'(i) == fill_reg) ? in_item.symbol : win_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                fill_reg      <= fill_next;
                idx_reg       <= idx_next;
                job_valid_reg <= 1'b1;
            end
            else if (job_valid_reg && job_ready)
                job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < SPAN; i++)
            begin
                win_reg[i]        <= in_item.seq_end ? 8'd0 : nw[i];
                jw_reg[8*i +: 8]  <= nw[i];
            end
            jb_reg <= idx_reg - POS_W'(SPAN - 1);
            jf_reg <= (fill_reg == FW'(SPAN)) || (fill_reg == FW'(SPAN - 1));
            je_reg <= in_item.seq_end;
        end
    end

    assign job_valid  = job_valid_reg;
    assign job_window = jw_reg;
    assign job_base   = jb_reg;
    assign job_full   = jf_reg;
    assign job_end    = je_reg;
endmodule
`default_nettype wire

// ===== sv/wmf_back.sv =====
// Back: scans k-mers, one per cycle when not stalled; emits changed minimizers.
`default_nettype none
module wmf_back #(
    parameter int KMER_LEN   = wmf_pkg::KMER_LEN_DEF,
    parameter int WINDOW_LEN = wmf_pkg::WINDOW_LEN_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    output logic      job_ready,
    input  wire logic [8*(WINDOW_LEN+KMER_LEN-1)-1:0] job_window,
    input  wire logic [wmf_pkg::POS_W-1:0]            job_base,
    input  wire logic job_full,
    input  wire logic job_end,
    output logic      out_valid,
    input  wire logic out_ready,
    output wmf_pkg::wmf_out_t out_item
);
    import wmf_pkg::*;
    localparam int SPAN = WINDOW_LEN + KMER_LEN - 1;
    localparam int KW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int KB   = 8 * KMER_LEN;
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic             state_reg;
    logic [8*SPAN-1:0] win_reg;
    logic [POS_W-1:0] base_reg;
    logic             end_reg;
    logic [KW-1:0]    k_reg, best_reg;
    logic [KB-1:0]    best_kmer_reg, cand;
    logic [POS_W-1:0] last_reg;
    logic             have_reg;
    logic             ov_reg;
    wmf_out_t         out_reg;

    // Byte 0 is the first character, so compare with it as most significant.
    function automatic logic [KB-1:0] be(input logic [KB-1:0] v);
        logic [KB-1:0] r;
        for (int t = 0; t < KMER_LEN; t++)
            r[KB-1-8*t -: 8] = v[8*t +: 8];
        return r;
    endfunction

    assign cand = be(win_reg[8*k_reg +: KB]);
    logic last_step;
    assign last_step = (k_reg == KW'(WINDOW_LEN - 1));
    logic [KW-1:0]    best_fin;
    assign best_fin = (cand < best_kmer_reg) ? k_reg : best_reg;
    logic [POS_W-1:0] pos, pos_diff;
    assign pos      = base_reg + POS_W'(best_fin);
    assign pos_diff = pos - last_reg;
    logic emit;
    assign emit = !have_reg || pos != last_reg;

    // Hold the scan while a result still waits to be taken.
    logic can_finish;
    assign can_finish = !ov_reg || out_ready;
    assign job_ready  = (state_reg == ST_IDLE);
    logic fire;
    assign fire = (state_reg == ST_SCAN) && last_step && can_finish && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            have_reg  <= 1'b0;
            last_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        if (job_full)
                            state_reg <= ST_SCAN;
                        else if (job_end)
                        begin
                            have_reg <= 1'b0;
                            last_reg <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (last_step && can_finish)
                    begin
                        state_reg <= ST_IDLE;
                        if (end_reg)
                        begin
                            have_reg <= 1'b0;
                            last_reg <= '0;
                        end
                        else if (emit)
                        begin
                            last_reg <= pos;
                            have_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            win_reg       <= job_window;
            base_reg      <= job_base;
            end_reg       <= job_end;
            k_reg         <= '0;
            best_reg      <= '0;
            best_kmer_reg <= '1;
        end
        else if (state_reg == ST_SCAN && !last_step)
        begin
            k_reg <= k_reg + 1'b1;
            if (k_reg == '0 || cand < best_kmer_reg)
            begin
                best_reg      <= k_reg;
                best_kmer_reg <= cand;
            end
        end
        if (fire)
        begin
            out_reg.position <= pos;
            out_reg.is_first <= !have_reg;
            out_reg.distance <= have_reg ? pos_diff[DIST_W-1:0] : '0;
            out_reg.gap      <= !have_reg ? pos :
                                (pos_diff > POS_W'(KMER_LEN) ?
                                 pos_diff - POS_W'(KMER_LEN) : '0);
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = out_reg;
endmodule
`default_nettype wire

// ===== sv/window_minimizer_finder_top.sv =====
// Top level: window minimizer finder with front/back split.
// Takes one character per transfer. Each window-complete character costs a
// load step in the back end, then one k-mer compare per cycle, holding on the
// last k-mer while a result waits; other characters need no scan. A one-entry
// queue lets the front take the next character while the back scans. Results
// come out of a register.
`default_nettype none
module window_minimizer_finder_top #(
    parameter int KMER_LEN   = wmf_pkg::KMER_LEN_DEF,
    parameter int WINDOW_LEN = wmf_pkg::WINDOW_LEN_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    wmf_stream_if.sink   in_ch,
    wmf_stream_if.source out_ch
);
    import wmf_pkg::*;
    localparam int SPAN = WINDOW_LEN + KMER_LEN - 1;

    logic              jv, jr, jf, je;
    logic [8*SPAN-1:0] jw;
    logic [POS_W-1:0]  jb;

    wmf_front #(.KMER_LEN(KMER_LEN), .WINDOW_LEN(WINDOW_LEN)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
        .job_valid(jv), .job_ready(jr), .job_window(jw), .job_base(jb),
        .job_full(jf), .job_end(je)
    );

    wmf_back #(.KMER_LEN(KMER_LEN), .WINDOW_LEN(WINDOW_LEN)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(jv), .job_ready(jr), .job_window(jw), .job_base(jb),
        .job_full(jf), .job_end(je),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload)
    );
endmodule
`default_nettype wire
